FILE: hdl/lfma_pkg.sv
// ----------------------------------------------------------------------------
// lfma_pkg - shared types and constants for the lowest free machine allocator
// Field widths, default sizes and the control word passed along the cell row.
// ----------------------------------------------------------------------------
package lfma_pkg;

	localparam int MAX_MACHINES_DEF = 256;
	localparam int TIME_BITS_DEF    = 21;

	localparam int FIELD_TIME_W  = 21;
	localparam int FIELD_INDEX_W = 8;
	localparam int FIELD_COUNT_W = 16;
	localparam int FIELD_INUSE_W = 9;

	localparam logic [FIELD_COUNT_W-1:0] COUNT_MAX = '1;

	// control part of a job word travelling down the row
	typedef struct packed {
		logic valid;    // a job occupies this slot
		logic claimed;  // a machine has taken the job
		logic opened;   // the machine was opened by this job
	} job_ctl_t;

endpackage

FILE: hdl/lfma_cell.sv
// ----------------------------------------------------------------------------
// lfma_cell - one machine slot of the allocator row
// Holds one machine's end time and use count; claims a passing job if free.
// ----------------------------------------------------------------------------
module lfma_cell #(
	parameter int TIME_BITS = lfma_pkg::TIME_BITS_DEF,
	parameter int IDX_W     = 8,
	parameter int CELL_IDX  = 0
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lfma_pkg::job_ctl_t               ctl_in,
	input  logic [TIME_BITS-1:0]             start_in,
	input  logic [TIME_BITS-1:0]             end_in,
	input  logic [IDX_W-1:0]                 idx_in,
	input  logic [lfma_pkg::FIELD_COUNT_W-1:0] cnt_in,
	output lfma_pkg::job_ctl_t               ctl_out,
	output logic [TIME_BITS-1:0]             start_out,
	output logic [TIME_BITS-1:0]             end_out,
	output logic [IDX_W-1:0]                 idx_out,
	output logic [lfma_pkg::FIELD_COUNT_W-1:0] cnt_out
);

	logic                              open_q;
	logic [TIME_BITS-1:0]              end_time_q;
	logic [lfma_pkg::FIELD_COUNT_W-1:0] use_cnt_q;
	lfma_pkg::job_ctl_t                ctl_q;
	logic [TIME_BITS-1:0]              start_q;
	logic [TIME_BITS-1:0]              end_q;
	logic [IDX_W-1:0]                  idx_q;
	logic [lfma_pkg::FIELD_COUNT_W-1:0] cnt_q;
	logic                              hit;
	logic [lfma_pkg::FIELD_COUNT_W-1:0] next_cnt;

	// free if never opened (first such cell in row) or finished by start time
	assign hit = ctl_in.valid && !ctl_in.claimed && (!open_q || (end_time_q <= start_in));

	always_comb begin
		if (!open_q) begin
			next_cnt = lfma_pkg::FIELD_COUNT_W'(1);
		end else if (use_cnt_q == lfma_pkg::COUNT_MAX) begin
			next_cnt = use_cnt_q;
		end else begin
			next_cnt = use_cnt_q + lfma_pkg::FIELD_COUNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			ctl_q  <= '0;
		end else begin
			if (hit) begin
				open_q <= 1'b1;
			end
			ctl_q.valid   <= ctl_in.valid;
			ctl_q.claimed <= ctl_in.claimed || hit;
			ctl_q.opened  <= hit ? !open_q : ctl_in.opened;
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			end_time_q <= end_in;
			use_cnt_q  <= next_cnt;
		end
		start_q <= start_in;
		end_q   <= end_in;
		idx_q   <= hit ? IDX_W'(CELL_IDX) : idx_in;
		cnt_q   <= hit ? next_cnt : cnt_in;
	end

	assign ctl_out   = ctl_q;
	assign start_out = start_q;
	assign end_out   = end_q;
	assign idx_out   = idx_q;
	assign cnt_out   = cnt_q;

endmodule

FILE: hdl/lfma_out.sv
// ----------------------------------------------------------------------------
// lfma_out - result stage of the allocator
// Registers the result word and keeps the count of opened machines.
// ----------------------------------------------------------------------------
module lfma_out #(
	parameter int MAX_MACHINES = lfma_pkg::MAX_MACHINES_DEF,
	parameter int IDX_W        = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lfma_pkg::job_ctl_t                 ctl_in,
	input  logic [IDX_W-1:0]                   idx_in,
	input  logic [lfma_pkg::FIELD_COUNT_W-1:0] cnt_in,
	output logic                               done,
	output logic [lfma_pkg::FIELD_INDEX_W-1:0] machine_index,
	output logic [lfma_pkg::FIELD_COUNT_W-1:0] use_count,
	output logic                               new_machine,
	output logic [lfma_pkg::FIELD_INUSE_W-1:0] machines_in_use,
	output logic                               pool_full
);

	localparam int CNT_W = $clog2(MAX_MACHINES + 1);

	logic [CNT_W-1:0] open_cnt_q;
	logic [CNT_W-1:0] open_next;
	logic             done_q;

	assign open_next = open_cnt_q + CNT_W'(ctl_in.valid && ctl_in.opened);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_cnt_q <= '0;
			done_q     <= 1'b0;
		end else begin
			open_cnt_q <= open_next;
			done_q     <= ctl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.valid) begin
			machine_index   <= ctl_in.claimed ? lfma_pkg::FIELD_INDEX_W'(idx_in) : '0;
			use_count       <= ctl_in.claimed ? cnt_in : '0;
			new_machine     <= ctl_in.opened;
			pool_full       <= !ctl_in.claimed;
			machines_in_use <= lfma_pkg::FIELD_INUSE_W'(open_next);
		end
	end

	assign done = done_q;

endmodule

FILE: hdl/lowest_free_machine_allocator.sv
// ----------------------------------------------------------------------------
// lowest_free_machine_allocator - interval partitioning, lowest index first
// Gives each job the lowest-numbered machine free at its start time.
// ----------------------------------------------------------------------------
// A job word (start_time, end_time) is taken whenever start is high; busy is
// never raised, so one word can enter in every cycle. The word walks down a
// row of MAX_MACHINES cells, one cell per cycle, and each cell holds one
// machine. The first cell whose machine has ended by the start time, or the
// first cell not yet opened, claims the job and updates its machine. Because
// words keep their order and each one meets a cell only after all earlier
// words have passed it, the outcome is that of handling jobs one at a time.
// Each cell registers the word as it passes, cell 0 at the edge that takes it,
// and the result register at the end of the row then raises done with it.
// Each result is shown for one cycle with done high; the receiver cannot
// stall, so every result must be taken in that cycle. Results come out in
// input order, one per job.
// A job that finds no free machine when the pool is full gives pool_full
// with index and count zero and leaves the state alone.
// ----------------------------------------------------------------------------
module lowest_free_machine_allocator #(
	parameter int MAX_MACHINES = lfma_pkg::MAX_MACHINES_DEF,
	parameter int TIME_BITS    = lfma_pkg::TIME_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [lfma_pkg::FIELD_TIME_W-1:0]  start_time,
	input  logic [lfma_pkg::FIELD_TIME_W-1:0]  end_time,
	output logic                               done,
	output logic [lfma_pkg::FIELD_INDEX_W-1:0] machine_index,
	output logic [lfma_pkg::FIELD_COUNT_W-1:0] use_count,
	output logic                               new_machine,
	output logic [lfma_pkg::FIELD_INUSE_W-1:0] machines_in_use,
	output logic                               pool_full
);

	localparam int IDX_W = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;

	// chain taps: slot k is the input of cell k, slot MAX_MACHINES the row end
	lfma_pkg::job_ctl_t                 ctl_c   [0:MAX_MACHINES];
	logic [TIME_BITS-1:0]               start_c [0:MAX_MACHINES];
	logic [TIME_BITS-1:0]               end_c   [0:MAX_MACHINES];
	logic [IDX_W-1:0]                   idx_c   [0:MAX_MACHINES];
	logic [lfma_pkg::FIELD_COUNT_W-1:0] cnt_c   [0:MAX_MACHINES];

	// the row never blocks
	assign busy = 1'b0;

	// job word enters the head of the row, only the low time bits count
	assign ctl_c[0].valid   = start && !busy;
	assign ctl_c[0].claimed = 1'b0;
	assign ctl_c[0].opened  = 1'b0;
	assign start_c[0]       = TIME_BITS'(start_time);
	assign end_c[0]         = TIME_BITS'(end_time);
	assign idx_c[0]         = '0;
	assign cnt_c[0]         = '0;

	generate
		for (genvar k = 0; k < MAX_MACHINES; k++) begin : g_cell
			lfma_cell #(
				.TIME_BITS (TIME_BITS),
				.IDX_W     (IDX_W),
				.CELL_IDX  (k)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl_in    (ctl_c[k]),
				.start_in  (start_c[k]),
				.end_in    (end_c[k]),
				.idx_in    (idx_c[k]),
				.cnt_in    (cnt_c[k]),
				.ctl_out   (ctl_c[k+1]),
				.start_out (start_c[k+1]),
				.end_out   (end_c[k+1]),
				.idx_out   (idx_c[k+1]),
				.cnt_out   (cnt_c[k+1])
			);
		end
	endgenerate

	// result register and opened-machine count at the end of the row
	lfma_out #(
		.MAX_MACHINES (MAX_MACHINES),
		.IDX_W        (IDX_W)
	) u_out (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl_in          (ctl_c[MAX_MACHINES]),
		.idx_in          (idx_c[MAX_MACHINES]),
		.cnt_in          (cnt_c[MAX_MACHINES]),
		.done            (done),
		.machine_index   (machine_index),
		.use_count       (use_count),
		.new_machine     (new_machine),
		.machines_in_use (machines_in_use),
		.pool_full       (pool_full)
	);

	// a dropped job never opens a machine
	a_full_not_new: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(pool_full && new_machine))
		else $error("dropped job marked as opening a machine");

	// a dropped job reports no machine and no count
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && pool_full) |-> (use_count == '0 && machine_index == '0))
		else $error("dropped job carries index or count");

	// a freshly opened machine has served exactly this job
	a_new_count_one: assert property (@(posedge clk) disable iff (!arst_n)
		(done && new_machine) |-> (use_count == lfma_pkg::FIELD_COUNT_W'(1)))
		else $error("new machine with count other than one");

	// a served job always has a count of at least one
	a_served_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !pool_full) |-> (use_count != '0))
		else $error("served job with zero count");

endmodule
